[design/sfw_pkg.sv]
// shared types, codes and byte helpers for the word-case substring finder
package sfw_pkg;

	localparam logic MODE_PATTERN = 1'b0;
	localparam logic MODE_TEXT    = 1'b1;

	localparam logic [0:0] REG_IGNORE_CASE = 1'b0;
	localparam logic [0:0] REG_WHOLE_WORD  = 1'b1;

	localparam logic [1:0] ST_FOUND       = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND   = 2'd1;
	localparam logic [1:0] ST_BAD_PATTERN = 2'd2;

	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
	localparam logic [7:0] CASE_OFFSET = 8'd32;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_NEWLINE  = 8'h0a;

	typedef enum logic [1:0] {
		VERD_UNDECIDED = 2'd0,
		VERD_FOUND     = 2'd1,
		VERD_REJECTED  = 2'd2
	} verdict_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] match_position;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic take;
		logic last;
	} step_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
		logic [7:0] r;
		r = c;
		if (ic && (c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic logic is_gap(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
	endfunction

endpackage

[design/sfw_pattern.sv]
// pattern store: newest byte at index zero, length, overflow and closed flags
module sfw_pattern import sfw_pkg::*; #(
	parameter int MAX_PATTERN = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  step_t                                    step,
	input  logic [7:0]                               data_byte,
	output logic [MAX_PATTERN-1:0][7:0]              pat_rev,
	output logic [$clog2(MAX_PATTERN+1)-1:0]         pat_len,
	output logic                                     pat_ok
);

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic [MAX_PATTERN-1:0][7:0] pat_q;
	logic [LW-1:0]               len_q;
	logic                        ovf_q;
	logic                        done_q;
	logic [LW-1:0]               len_base;
	logic                        ovf_base;
	logic                        room;

	always_comb begin
		len_base = done_q ? '0 : len_q;
		ovf_base = done_q ? 1'b0 : ovf_q;
		room     = len_base < LW'(MAX_PATTERN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (step.load) begin
			len_q  <= room ? len_base + 1'b1 : len_base;
			ovf_q  <= ovf_base | ~room;
			done_q <= step.last;
		end else if (step.take) begin
			done_q <= 1'b1;
		end
	end

	// shift in so that the last loaded byte sits at index zero
	always_ff @(posedge clk) begin
		if (step.load && room) begin
			pat_q[0] <= data_byte;
			for (int k = 1; k < MAX_PATTERN; k++) begin
				pat_q[k] <= pat_q[k - 1];
			end
		end
	end

	assign pat_rev = pat_q;
	assign pat_len = len_q;
	assign pat_ok  = !ovf_q && (len_q != '0);

endmodule

[design/sfw_window.sv]
// text window, parallel pattern compare, first-match tracking and verdict
module sfw_window import sfw_pkg::*; #(
	parameter int              MAX_PATTERN = 32,
	parameter longint unsigned MAX_TEXT    = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  step_t                            step,
	input  logic [7:0]                       data_byte,
	input  logic                             ignore_case,
	input  logic                             whole_word,
	input  logic [MAX_PATTERN-1:0][7:0]      pat_rev,
	input  logic [$clog2(MAX_PATTERN+1)-1:0] pat_len,
	input  logic                             pat_ok,
	output out_word_t                        result
);

	localparam int LW   = $clog2(MAX_PATTERN + 1);
	localparam int CW   = $clog2(MAX_TEXT + 1);
	localparam int CMPW = (CW > LW) ? CW : LW;

	logic [MAX_PATTERN-1:0][7:0] win_q;
	logic [MAX_PATTERN:0][7:0]   w_new;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               count_nx;
	logic                        seen_q;
	logic                        seen_nx;
	logic [15:0]                 start_q;
	logic [15:0]                 start_nx;
	verdict_t                    verd_q;
	verdict_t                    verd_nx;
	logic [MAX_PATTERN-1:0]      k_hit;
	logic                        all_hit;
	logic                        full;
	logic [7:0]                  prev_byte;

	always_comb begin
		w_new   = {win_q, data_byte};
		for (int k = 0; k < MAX_PATTERN; k++) begin
			k_hit[k] = (LW'(k) >= pat_len) ||
				(fold_byte(pat_rev[k], ignore_case) == fold_byte(w_new[k], ignore_case));
		end
		all_hit   = &k_hit;
		prev_byte = w_new[pat_len];
		full      = (count_q == CW'(MAX_TEXT));
		count_nx  = count_q;
		seen_nx   = seen_q;
		start_nx  = start_q;
		verd_nx   = verd_q;
		if (step.take && !full) begin
			count_nx = count_q + 1'b1;
			if (seen_q) begin
				if (verd_q == VERD_UNDECIDED) begin
					verd_nx = is_gap(data_byte) ? VERD_FOUND : VERD_REJECTED;
				end
			end else if (pat_ok && (CMPW'(count_nx) >= CMPW'(pat_len)) && all_hit) begin
				seen_nx  = 1'b1;
				start_nx = 16'(CMPW'(count_nx) - CMPW'(pat_len));
				if (!whole_word) begin
					verd_nx = VERD_FOUND;
				end else if ((CMPW'(count_nx) != CMPW'(pat_len)) && !is_gap(prev_byte)) begin
					verd_nx = VERD_REJECTED;
				end
			end
		end
		result.match_position = '0;
		if (!pat_ok) begin
			result.status = ST_BAD_PATTERN;
		end else if (seen_nx && (verd_nx != VERD_REJECTED)) begin
			result.status         = ST_FOUND;
			result.match_position = start_nx;
		end else begin
			result.status = ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			seen_q  <= 1'b0;
			start_q <= '0;
			verd_q  <= VERD_UNDECIDED;
		end else if (step.load || (step.take && step.last)) begin
			count_q <= '0;
			seen_q  <= 1'b0;
			start_q <= '0;
			verd_q  <= VERD_UNDECIDED;
		end else begin
			count_q <= count_nx;
			seen_q  <= seen_nx;
			start_q <= start_nx;
			verd_q  <= verd_nx;
		end
	end

	// only entries written during the current text are ever compared
	always_ff @(posedge clk) begin
		if (step.take && !full) begin
			win_q <= w_new[MAX_PATTERN-1:0];
		end
	end

endmodule

[design/substring_find_word_case.sv]
// top level: input register, config registers, search core and result register
// Finds the first occurrence of a loaded pattern (up to MAX_PATTERN bytes) in a
// stream of text bytes, optionally ignoring ASCII case and optionally requiring
// whitespace or a text boundary on both sides of that first occurrence. Pattern
// words (mode 0) and text words (mode 1) are accepted at one word per cycle,
// back to back; the whole window compare against every pattern position is done
// in one pass between the input register and the result register, so a result
// is loaded into the result register as the last text word leaves the input register.
// The input stalls only while a finished result waits in a stalled result register.
// A pattern word after text abandons the running search. Text past MAX_TEXT
// bytes is ignored until last_byte. Write the config only while no word is in flight.
module substring_find_word_case import sfw_pkg::*; #(
	parameter int              MAX_PATTERN = 32,
	parameter longint unsigned MAX_TEXT    = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_word_t   in_word,
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_word,
	input  logic       cfg_wen,
	input  logic [0:0] cfg_index,
	input  logic [0:0] cfg_data
);

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic                        ignore_case_q;
	logic                        whole_word_q;
	logic                        valid_s1;
	in_word_t                    word_s1;
	logic                        produces;
	logic                        out_free;
	logic                        adv;
	step_t                       step;
	logic [MAX_PATTERN-1:0][7:0] pat_rev;
	logic [LW-1:0]               pat_len;
	logic                        pat_ok;
	out_word_t                   result;
	logic                        out_valid_q;
	out_word_t                   out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_case_q <= 1'b0;
			whole_word_q  <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_IGNORE_CASE: ignore_case_q <= cfg_data[0];
				REG_WHOLE_WORD:  whole_word_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		produces  = (word_s1.mode == MODE_TEXT) && word_s1.last_byte;
		out_free  = !out_valid_q || !out_stall;
		adv       = valid_s1 && (!produces || out_free);
		in_stall  = valid_s1 && !adv;
		step.load = adv && (word_s1.mode == MODE_PATTERN);
		step.take = adv && (word_s1.mode == MODE_TEXT);
		step.last = word_s1.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
	end

	sfw_pattern #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_pattern (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.data_byte(word_s1.data_byte),
		.pat_rev  (pat_rev),
		.pat_len  (pat_len),
		.pat_ok   (pat_ok)
	);

	sfw_window #(
		.MAX_PATTERN(MAX_PATTERN),
		.MAX_TEXT   (MAX_TEXT)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (word_s1.data_byte),
		.ignore_case(ignore_case_q),
		.whole_word (whole_word_q),
		.pat_rev    (pat_rev),
		.pat_len    (pat_len),
		.pat_ok     (pat_ok),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && produces) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produces) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
